/* design/bblur_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblur_pkg
// Shared types, constants and the reciprocal table of the 3x3 box blur.
// ----------------------------------------------------------------------------
package bblur_pkg;

    localparam int CH_W        = 8;
    localparam int NUM_CH      = 3;
    localparam int PIX_W       = CH_W * NUM_CH;
    localparam int SUM_W       = 12;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int DIM_RESET   = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Pixels hold blue in the top byte and red in the bottom byte.
    typedef logic [PIX_W-1:0] t_pix;
    // Column of the window: index 0 is the top row, index 2 the bottom row.
    typedef t_pix [2:0] t_col;
    // Window: index 0 is the left column, index 2 the right column.
    typedef t_col [2:0] t_win;

    typedef struct packed {
        logic emit;
        logic last;
        logic row_top_ok;
        logic row_bot_ok;
        logic col_lft_ok;
        logic col_rgt_ok;
    } t_blur_ctl;

    // Rounded-up reciprocal of the neighbor count, exact for sums up to 2295.
    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] cnt);
        logic [RECIP_W-1:0] val;
        case (cnt)
            4'd1:    val = RECIP_W'(65536);
            4'd2:    val = RECIP_W'(32768);
            4'd3:    val = RECIP_W'(21846);
            4'd4:    val = RECIP_W'(16384);
            4'd5:    val = RECIP_W'(13108);
            4'd6:    val = RECIP_W'(10923);
            4'd7:    val = RECIP_W'(9363);
            4'd8:    val = RECIP_W'(8192);
            4'd9:    val = RECIP_W'(7282);
            default: val = RECIP_W'(65536);
        endcase
        return val;
    endfunction

endpackage

/* design/bblur_line_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblur_line_mem
// Line buffer memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bblur_line_mem #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 48,
    parameter int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

/* design/bblur_avg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblur_avg
// Sums the in-frame neighbors of the window per channel and divides by their
// count through a reciprocal multiply.
// ----------------------------------------------------------------------------
module bblur_avg (
    input  logic                 i_clk,
    input  bblur_pkg::t_win      i_win,
    input  bblur_pkg::t_blur_ctl i_ctl,
    output bblur_pkg::t_pix      o_avg
);
    import bblur_pkg::*;

    logic [SUM_W-1:0]   n_sum [NUM_CH];
    logic [SUM_W-1:0]   r_sum [NUM_CH];
    logic [RECIP_W-1:0] r_recip;
    logic [1:0]         row_ok_cnt;
    logic [1:0]         col_ok_cnt;
    logic [3:0]         nb_cnt;
    logic [2:0]         row_use;
    logic [2:0]         col_use;
    logic [SUM_W+RECIP_W-1:0] prod [NUM_CH];

    always_comb begin
        row_use = {i_ctl.row_bot_ok, 1'b1, i_ctl.row_top_ok};
        col_use = {i_ctl.col_rgt_ok, 1'b1, i_ctl.col_lft_ok};
        row_ok_cnt = 2'd1 + {1'b0, i_ctl.row_top_ok} + {1'b0, i_ctl.row_bot_ok};
        col_ok_cnt = 2'd1 + {1'b0, i_ctl.col_lft_ok} + {1'b0, i_ctl.col_rgt_ok};
        nb_cnt = {2'b00, row_ok_cnt} * {2'b00, col_ok_cnt};
        for (int k = 0; k < NUM_CH; k++) begin
            n_sum[k] = '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    if (col_use[i] && row_use[j]) begin
                        n_sum[k] = n_sum[k]
                            + SUM_W'(i_win[i][j][PIX_W-1-CH_W*k -: CH_W]);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum   <= n_sum;
        r_recip <= recip(nb_cnt);
    end

    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            prod[k] = (SUM_W+RECIP_W)'(r_sum[k]) * (SUM_W+RECIP_W)'(r_recip);
            o_avg[PIX_W-1-CH_W*k -: CH_W] = prod[k][RECIP_SHIFT +: CH_W];
        end
    end

endmodule

/* design/box_blur_3x3_rgb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// 3x3 box blur of an RGB raster stream with two line buffers in one memory.
// ----------------------------------------------------------------------------
// Each pixel goes through the line memory read, the read-modify-write of the
// memory together with the window shift, the neighbor sum, and the reciprocal
// multiply into the output register, where it waits while that register is
// full. The next pixel is accepted only after that. A blurred pixel leaves
// one row and one pixel after its input, so frame_width+1 pad transactions
// (tuser high) must follow a frame to flush it; tlast marks the frame's last
// result. A configuration write restarts the frame.
module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bblur_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bblur_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [23:0]                    i_s_tdata,  // in_red, in_green, in_blue
    input  logic                           i_s_tuser,  // pad
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [23:0]                    o_m_tdata,  // out_red, out_green, out_blue
    output logic                           o_m_tlast   // frame_last
);
    import bblur_pkg::*;

    localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WD_W = $clog2(MAX_WIDTH + 1);
    localparam int HT_W = $clog2(MAX_HEIGHT + 1);
    localparam int RW   = $clog2(MAX_HEIGHT + 3);
    localparam int PW0  = (RW > WD_W) ? RW : WD_W;
    localparam int PW1  = (PW0 > HT_W) ? PW0 : HT_W;
    localparam int PW   = ((PW1 > CFG_W) ? PW1 : CFG_W) + 1;
    localparam int WIDTH_RST  = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET;
    localparam int HEIGHT_RST = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET;

    typedef enum logic [1:0] {S_IDLE, S_UPD, S_SUM, S_DIV} t_state;

    t_state          r_state;
    logic [WD_W-1:0] r_width;
    logic [HT_W-1:0] r_height;
    logic [AW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    t_pix            r_pix;
    t_win            r_win;
    t_blur_ctl       r_ctl;

    logic [AW-1:0]   n_col;
    logic [RW-1:0]   n_row;
    t_win            n_win;
    t_blur_ctl       n_ctl;
    logic [WD_W-1:0] n_width;
    logic [HT_W-1:0] n_height;

    logic [2*PIX_W-1:0] rd_data;
    t_pix            rd_above;
    t_pix            rd_cur;
    t_pix            avg;
    logic            s_fire;
    logic            out_free;

    logic [PW-1:0]   c_ext, r_ext, w_ext, h_ext, cr, cc, c_nxt, cfg_ext;
    logic            br_row_end, br_mid, wrap;

    assign o_s_tready = i_rst_n && (r_state == S_IDLE);
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign out_free   = !o_m_tvalid || i_m_tready;
    assign rd_above   = rd_data[2*PIX_W-1:PIX_W];
    assign rd_cur     = rd_data[PIX_W-1:0];

    bblur_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (2 * PIX_W),
        .AW     (AW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (s_fire),
        .i_rd_addr (r_col),
        .o_rd_data (rd_data),
        .i_wr_en   (r_state == S_UPD),
        .i_wr_addr (r_col),
        .i_wr_data ({rd_cur, r_pix})
    );

    bblur_avg u_avg (
        .i_clk (i_clk),
        .i_win (r_win),
        .i_ctl (r_ctl),
        .o_avg (avg)
    );

    always_comb begin
        c_ext   = PW'(r_col);
        r_ext   = PW'(r_row);
        w_ext   = PW'(r_width);
        h_ext   = PW'(r_height);
        cfg_ext = PW'(i_cfg_data);

        br_row_end = (r_col == '0) && (r_ext >= PW'(2));
        br_mid     = (r_col != '0) && (r_ext >= PW'(1));
        cr = br_row_end ? (r_ext - PW'(2)) : (r_ext - PW'(1));
        cc = br_row_end ? (w_ext - PW'(1)) : (c_ext - PW'(1));

        n_ctl.emit       = (br_row_end || br_mid) && (cr < h_ext);
        n_ctl.last       = n_ctl.emit && (cr == h_ext - PW'(1)) && (cc == w_ext - PW'(1));
        n_ctl.row_top_ok = (cr >= PW'(1));
        n_ctl.row_bot_ok = (cr + PW'(1) < h_ext);
        n_ctl.col_lft_ok = (cc >= PW'(1));
        n_ctl.col_rgt_ok = (cc + PW'(1) < w_ext);

        n_win[0]    = r_win[1];
        n_win[1]    = r_win[2];
        n_win[2][0] = rd_above;
        n_win[2][1] = rd_cur;
        n_win[2][2] = r_pix;

        c_nxt = c_ext + PW'(1);
        wrap  = (c_nxt >= w_ext);
        if (n_ctl.last) begin
            n_col = '0;
            n_row = '0;
        end else if (wrap) begin
            n_col = '0;
            n_row = (r_ext <= h_ext + PW'(1)) ? RW'(r_ext + PW'(1)) : r_row;
        end else begin
            n_col = AW'(c_nxt);
            n_row = r_row;
        end

        if (cfg_ext == '0) begin
            n_width  = WD_W'(1);
            n_height = HT_W'(1);
        end else begin
            n_width  = (cfg_ext > PW'(MAX_WIDTH))  ? WD_W'(MAX_WIDTH)  : WD_W'(cfg_ext);
            n_height = (cfg_ext > PW'(MAX_HEIGHT)) ? HT_W'(MAX_HEIGHT) : HT_W'(cfg_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_width    <= WD_W'(WIDTH_RST);
            r_height   <= HT_W'(HEIGHT_RST);
            r_col      <= '0;
            r_row      <= '0;
            r_win      <= '0;
            r_ctl      <= '0;
            o_m_tvalid <= 1'b0;
            o_m_tlast  <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready && !(r_state == S_DIV && r_ctl.emit)) begin
                o_m_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_fire) begin
                        r_pix   <= i_s_tuser ? '0
                                 : {i_s_tdata[7:0], i_s_tdata[15:8], i_s_tdata[23:16]};
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_win   <= n_win;
                    r_ctl   <= n_ctl;
                    r_col   <= n_col;
                    r_row   <= n_row;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!r_ctl.emit) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        o_m_tvalid <= 1'b1;
                        o_m_tlast  <= r_ctl.last;
                        o_m_tdata  <= {avg[7:0], avg[15:8], avg[23:16]};
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH: begin
                        r_width <= n_width;
                        r_col   <= '0;
                        r_row   <= '0;
                    end
                    REG_FRAME_HEIGHT: begin
                        r_height <= n_height;
                        r_col    <= '0;
                        r_row    <= '0;
                    end
                    default: begin
                        r_col <= r_col;
                    end
                endcase
            end
        end
    end

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PW'(r_col) < PW'(r_width))
        else $error("column position reached the frame width");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PW'(r_row) <= PW'(r_height) + PW'(2))
        else $error("row position ran past the flush rows");

    a_accept_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> r_state == S_UPD)
        else $error("accepted transaction did not reach the memory update");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_ctl.emit && out_free && !i_cfg_we)
        |=> (o_m_tvalid && r_state == S_IDLE))
        else $error("blurred pixel was not loaded into the output register");

    a_no_result_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_ctl.emit && !out_free) |=> r_state == S_DIV)
        else $error("result left while the output register was full");

endmodule

/* bench/box_blur_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_checker
// Watches the configuration port and both stream channels of the 3x3 blur,
// keeps its own copy of the line buffers, window and raster position, works
// out the blurred pixel that each accepted input transaction releases, and
// compares every output transaction field by field with the oldest one due.
// ----------------------------------------------------------------------------
module box_blur_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bblur_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bblur_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [23:0]                     i_s_tdata,  // in_red, in_green, in_blue
    input  logic                            i_s_tuser,  // pad
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [23:0]                     i_m_tdata,  // out_red, out_green, out_blue
    input  logic                            i_m_tlast,  // frame_last
    output int                              o_fail_count,
    output int                              o_pending
);
    import bblur_pkg::*;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgb;

    typedef struct packed {
        t_rgb color;
        logic last;
    } t_blurred;

    t_rgb        line_above [MAX_WIDTH];
    t_rgb        line_cur [MAX_WIDTH];
    t_rgb        win_cols [3][3];  // [left..right][top..bottom]
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned frame_w;
    int unsigned frame_h;
    t_blurred    blurred_q [$];
    int          fail_count;

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                              input int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic t_rgb neighbor_average(input int lc, input int mc, input int rc,
                                              input int unsigned cr, input int unsigned cc);
        int          cols [3];
        bit          row_ok [3];
        bit          col_ok [3];
        int unsigned sum_r;
        int unsigned sum_g;
        int unsigned sum_b;
        int unsigned cnt;
        t_rgb        avg;
        cols[0]   = lc;
        cols[1]   = mc;
        cols[2]   = rc;
        row_ok[0] = cr >= 1;
        row_ok[1] = 1'b1;
        row_ok[2] = cr + 1 < frame_h;
        col_ok[0] = cc >= 1;
        col_ok[1] = 1'b1;
        col_ok[2] = cc + 1 < frame_w;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        cnt   = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (col_ok[i] && row_ok[j]) begin
                    sum_r += win_cols[cols[i]][j].red;
                    sum_g += win_cols[cols[i]][j].green;
                    sum_b += win_cols[cols[i]][j].blue;
                    cnt++;
                end
            end
        end
        avg.red   = 8'(sum_r / cnt);
        avg.green = 8'(sum_g / cnt);
        avg.blue  = 8'(sum_b / cnt);
        return avg;
    endfunction

    task automatic shift_in_pixel(input logic pad, input t_rgb px);
        int unsigned c;
        int unsigned r;
        int unsigned idx;
        int unsigned cr;
        int unsigned cc;
        t_rgb        newpx;
        t_rgb        above;
        t_rgb        cur;
        t_rgb        avg;
        bit          emit;
        bit          last;
        c     = col_pos;
        r     = row_pos;
        cr    = 0;
        cc    = 0;
        emit  = 1'b0;
        avg   = '0;
        newpx = pad ? t_rgb'(0) : px;

        // At the start of a row the right edge of the row before last is due.
        if (c == 0 && r >= 2) begin
            cr   = r - 2;
            cc   = frame_w - 1;
            emit = cr < frame_h;
            if (emit) avg = neighbor_average(1, 2, 2, cr, cc);
        end

        idx   = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
        above = line_above[idx];
        cur   = line_cur[idx];
        line_above[idx] = cur;
        line_cur[idx]   = newpx;
        for (int j = 0; j < 3; j++) begin
            win_cols[0][j] = win_cols[1][j];
            win_cols[1][j] = win_cols[2][j];
        end
        win_cols[2][0] = above;
        win_cols[2][1] = cur;
        win_cols[2][2] = newpx;

        if (c >= 1 && r >= 1) begin
            cr   = r - 1;
            cc   = c - 1;
            emit = cr < frame_h;
            if (emit) avg = neighbor_average(0, 1, 2, cr, cc);
        end

        last = emit && cr == frame_h - 1 && cc == frame_w - 1;
        if (last) begin
            col_pos = 0;
            row_pos = 0;
        end else begin
            c++;
            if (c >= frame_w) begin
                c = 0;
                if (r <= frame_h + 1) r++;
            end
            col_pos = c;
            row_pos = r;
        end

        if (emit) blurred_q.push_back({avg, last});
    endtask

    always @(posedge i_clk) begin
        t_blurred due;
        t_rgb     got;
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_WIDTH; k++) begin
                line_above[k] = '0;
                line_cur[k]   = '0;
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_cols[i][j] = '0;
                end
            end
            col_pos    = 0;
            row_pos    = 0;
            frame_w    = clamp_dim(CFG_W'(DIM_RESET), MAX_WIDTH);
            frame_h    = clamp_dim(CFG_W'(DIM_RESET), MAX_HEIGHT);
            fail_count = 0;
            blurred_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (blurred_q.size() == 0) begin
                    $display("%0t: unexpected output transaction, actual %h last %b",
                             $time, i_m_tdata, i_m_tlast);
                    fail_count++;
                end else begin
                    due = blurred_q.pop_front();
                    if (got.red !== due.color.red) begin
                        $display("%0t: red expected %h actual %h",
                                 $time, due.color.red, got.red);
                        fail_count++;
                    end
                    if (got.green !== due.color.green) begin
                        $display("%0t: green expected %h actual %h",
                                 $time, due.color.green, got.green);
                        fail_count++;
                    end
                    if (got.blue !== due.color.blue) begin
                        $display("%0t: blue expected %h actual %h",
                                 $time, due.color.blue, got.blue);
                        fail_count++;
                    end
                    if (i_m_tlast !== due.last) begin
                        $display("%0t: frame_last expected %b actual %b",
                                 $time, due.last, i_m_tlast);
                        fail_count++;
                    end
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH: begin
                        frame_w = clamp_dim(i_cfg_data, MAX_WIDTH);
                    end
                    REG_FRAME_HEIGHT: begin
                        frame_h = clamp_dim(i_cfg_data, MAX_HEIGHT);
                    end
                    default: begin
                    end
                endcase
                col_pos = 0;
                row_pos = 0;
            end

            if (i_s_tvalid && i_s_tready) shift_in_pixel(i_s_tuser, i_s_tdata);
        end
        o_pending    <= blurred_q.size();
        o_fail_count <= fail_count;
    end

endmodule

/* bench/tb_box_blur_3x3_rgb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_rgb
// Drives frames of random RGB pixels through the 3x3 box blur: a few small
// hand-built frames, the widest and tallest frames, then many small frames
// with random sizes, pads inside frames, pixels in the flush positions, cut
// frames and restarts, under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_rgb;
    import bblur_pkg::*;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 1024;
    localparam int RANDOM_ITEMS   = 1650;
    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [23:0]          i_s_tdata   = '0;  // in_red, in_green, in_blue
    logic                 i_s_tuser   = 1'b0;  // pad
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [23:0]          o_m_tdata;  // out_red, out_green, out_blue
    logic                 o_m_tlast;  // frame_last

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    int items_sent   = 0;
    int cur_w;
    int cur_h;
    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    bit pressure_on  = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    box_blur_3x3_rgb #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    box_blur_checker #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_m_tlast   (o_m_tlast),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [23:0] rand_pixel();
        logic [23:0] px;
        int          r;
        for (int k = 0; k < 3; k++) begin
            r = $urandom_range(0, 9);
            px[8*k +: 8] = (r == 0) ? 8'hFF : (r == 1) ? 8'h00 : 8'($urandom);
        end
        return px;
    endfunction

    task automatic send_item(input logic pad, input logic [23:0] data);
        int gap;
        gap = pick_gap(tx_idle_on);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= pad;
        i_s_tdata  <= data;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // A negative cut sends the whole frame and its flush.
    task automatic send_frame(input int w, input int h, input int pad_pct,
                              input int junk_pct, input int cut);
        int total;
        total = w * h + w + 1;
        if (cut >= 0 && cut < total) total = cut;
        for (int n = 0; n < total; n++) begin
            if (n < w * h) send_item($urandom_range(0, 99) < pad_pct, rand_pixel());
            else send_item($urandom_range(0, 99) >= junk_pct, rand_pixel());
        end
        items_sent += total;
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    task automatic program_frame(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val,
                                 input bit w_en, input bit h_en, input bit h_first);
        if (h_first && h_en) write_reg(REG_FRAME_HEIGHT, h_val);
        if (w_en) write_reg(REG_FRAME_WIDTH, w_val);
        if (!h_first && h_en) write_reg(REG_FRAME_HEIGHT, h_val);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        bit held;
        int r;
        held = 1'b0;
        wait (i_rst_n);
        forever begin
            if (pressure_on && !held) begin
                held = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (!pressure_on) held = 1'b0;
                if (!rx_idle_on) begin
                    i_m_tready <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge i_clk);
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 60) begin
                        i_m_tready <= 1'b1;
                        repeat ($urandom_range(1, 6)) @(posedge i_clk);
                    end else if (r < 92) begin
                        i_m_tready <= 1'b0;
                        repeat ($urandom_range(1, 3)) @(posedge i_clk);
                    end else begin
                        i_m_tready <= 1'b0;
                        repeat ($urandom_range(15, 60)) @(posedge i_clk);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int  phase;
        int  w;
        int  h;
        int  mode;
        int  kind;
        int  frames;
        bit  stop;
        logic [CFG_W-1:0] w_val;
        logic [CFG_W-1:0] h_val;

        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero in both registers is taken as a 1x1 frame.
        program_frame(0, 0, 1'b1, 1'b1, 1'b0);
        send_item(1'b0, 24'hFFFFFF);
        send_item(1'b1, 24'h000000);
        send_item(1'b1, 24'h000000);
        // A pad in the frame counts as a black pixel; pixels in the flush are unused.
        send_item(1'b1, 24'h123456);
        send_item(1'b0, 24'hFFFFFF);
        send_item(1'b0, 24'hAAAAAA);
        wait_idle();

        program_frame(3, 3, 1'b1, 1'b1, 1'b0);
        for (int n = 0; n < 9; n++) begin
            send_item(n == 4, (n % 2 == 0) ? 24'hFFFFFF : 24'h000000);
        end
        for (int n = 0; n < 4; n++) begin
            send_item(1'b1, 24'h000000);
        end
        wait_idle();

        // Widest and tallest frames, with values above the range clamped. Both
        // are cut short: the wide one just past its first row wrap.
        program_frame(CFG_W'(2047), 2, 1'b1, 1'b1, 1'b1);
        send_frame(MAX_WIDTH, 2, 5, 10, MAX_WIDTH + 8);
        wait_idle();
        program_frame(4, CFG_W'(2047), 1'b1, 1'b1, 1'b0);
        send_frame(4, MAX_HEIGHT, 5, 10, 64);
        cur_w = 4;
        cur_h = MAX_HEIGHT;

        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            wait_idle();
            tx_idle_on   = ($urandom_range(0, 3) != 0);
            rx_idle_on  <= ($urandom_range(0, 3) != 0);
            pressure_on <= (phase % 12 == 0);
            r_size: begin
                kind = $urandom_range(0, 9);
                w = (kind < 6) ? $urandom_range(1, 8) :
                    (kind < 9) ? $urandom_range(9, 32) : $urandom_range(33, 64);
                h = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 16);
            end
            if (phase % 12 == 0) begin
                w = 8;
                h = 6;
                tx_idle_on = 1'b0;
            end
            w_val = (w == 1 && $urandom_range(0, 1) == 1) ? CFG_W'(0) : CFG_W'(w);
            h_val = (h == 1 && $urandom_range(0, 1) == 1) ? CFG_W'(0) : CFG_W'(h);
            mode = $urandom_range(0, 9);
            if (phase % 12 == 0) mode = 2;
            if (mode == 0) begin
                program_frame(w_val, h_val, 1'b1, 1'b0, 1'b0);
                cur_w = w;
            end else if (mode == 1) begin
                program_frame(w_val, h_val, 1'b0, 1'b1, 1'b0);
                cur_h = h;
            end else begin
                program_frame(w_val, h_val, 1'b1, 1'b1, $urandom_range(0, 1));
                cur_w = w;
                cur_h = h;
            end

            frames = (phase % 12 == 0) ? 1 : $urandom_range(1, 3);
            stop = 1'b0;
            for (int f = 0; f < frames && !stop; f++) begin
                kind = $urandom_range(0, 9);
                if (phase % 12 == 0) kind = 9;
                if (kind == 0) begin
                    send_frame(cur_w, cur_h, 50, 50, $urandom_range(1, 10));
                    stop = 1'b1;
                end else if (kind == 1) begin
                    send_frame(cur_w, cur_h, 5, 10,
                               $urandom_range(1, cur_w * cur_h + cur_w));
                    stop = 1'b1;
                end else begin
                    send_frame(cur_w, cur_h, (kind < 5) ? 0 : (kind < 8) ? 5 : 30,
                               (kind < 6) ? 10 : 50, -1);
                end
            end
            phase++;
        end

        pressure_on <= 1'b0;
        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* box_blur_3x3_rgb.f */
design/bblur_pkg.sv
design/bblur_line_mem.sv
design/bblur_avg.sv
design/box_blur_3x3_rgb.sv
bench/box_blur_checker.sv
bench/tb_box_blur_3x3_rgb.sv
